// File: rtl/uelm_pkg.sv
// ----------------------------------------------------------------------------
// uelm_pkg
// shared types and constants for the ultrasonic echo level meter
// ----------------------------------------------------------------------------
package uelm_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned CfgWidth          = 16;
  localparam int unsigned RawWidth          = 16;
  localparam int unsigned LevelWidth        = 15;

  localparam logic [RawWidth-1:0]   RawMax     = 16'hFFFF;
  localparam logic [LevelWidth-1:0] LevelLimit = 15'd25600;

  // register reset values
  localparam logic [CfgWidth-1:0] TriggerTicksReset = 16'd800;
  localparam logic [CfgWidth-1:0] MinCountReset     = 16'd3000;
  localparam logic [CfgWidth-1:0] MaxCountReset     = 16'd48500;
  localparam logic [CfgWidth-1:0] ScaleFactorReset  = 16'd36873;

  // register indexes on the config channel
  typedef enum logic [1:0] {
    RegTriggerTicks = 2'd0,
    RegMinCount     = 2'd1,
    RegMaxCount     = 2'd2,
    RegScaleFactor  = 2'd3
  } cfg_reg_e;

endpackage

// File: rtl/uelm_if.sv
// ----------------------------------------------------------------------------
// uelm channel interfaces
// tick input, result output and register write channels
// ----------------------------------------------------------------------------
interface uelm_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, output start_request, output echo_level, input ready);
  modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

interface uelm_out_if
  import uelm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  trigger_out;
  logic                  result_valid;
  logic [LevelWidth-1:0] level_q8;
  logic [RawWidth-1:0]   raw_count;

  modport source (output valid, output trigger_out, output result_valid,
                  output level_q8, output raw_count, input ready);
  modport sink   (input valid, input trigger_out, input result_valid,
                  input level_q8, input raw_count, output ready);
endinterface

interface uelm_cfg_if
  import uelm_pkg::*;
;
  logic                valid;
  logic                ready;
  cfg_reg_e            index;
  logic [CfgWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ultrasonic_echo_level_meter.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_level_meter
// pulse-width ranger for an ultrasonic level sensor, one item per timer tick
// ----------------------------------------------------------------------------
// in_i carries one timer tick per item: start_request and the sampled echo
// pin level. out_o returns exactly one item per tick: the trigger pin level,
// result_valid, and when a measurement completes the raw echo width and the
// level in percent (Q8, at most 25600). cfg_i writes the four registers
// (trigger length, min count, max count, scale factor); it is always ready
// and is meant to be used only while no item is in flight.
// The ranger state (trigger countdown, echo edge detect, echo counter) is
// updated at the edge an item is accepted, so ticks are handled in order.
// Stage 1 registers the trigger bit, the result flag, the raw count and the
// clamped distance above min count; stage 2 does the 16x16 scale multiply
// and the level limit into the output register.
// An accepted item goes through the stage 1 and output registers to out_o;
// one item per cycle is taken while out_o is ready, bounded by the single
// multiplier stage. Ready flows back from out_o so a stalled receiver holds
// both stages, while an empty stage 1 still takes a new tick. Reset clears
// the ranger state, loads the register defaults and empties both stages.
// ----------------------------------------------------------------------------
module ultrasonic_echo_level_meter
  import uelm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  uelm_in_if.sink         in_i,
  uelm_cfg_if.sink        cfg_i,
  uelm_out_if.source      out_o
);

  typedef struct packed {
    logic                trigger_out;
    logic                result_valid;
    logic [RawWidth-1:0] diff;
    logic [RawWidth-1:0] raw_count;
  } s1_t;

  typedef struct packed {
    logic                  trigger_out;
    logic                  result_valid;
    logic [LevelWidth-1:0] level_q8;
    logic [RawWidth-1:0]   raw_count;
  } out_t;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // configuration registers
  logic [CfgWidth-1:0] trigger_ticks_q, min_count_q, max_count_q, scale_factor_q;

  // ranger state
  logic                   prev_echo_q, prev_echo_d;
  logic [CfgWidth-1:0]    trig_rem_q, trig_rem_d;
  logic                   waiting_q, waiting_d;
  logic [COUNT_WIDTH-1:0] echo_cnt_q, echo_cnt_d;

  // pipeline
  logic s1_valid_q, out_valid_q;
  s1_t  s1_q, s1_d;
  out_t out_q, out_d;
  logic s1_ready, s2_ready, in_acc;

  // per-tick logic
  logic [CfgWidth-1:0]    trig_load;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   rise, fall;
  logic [RawWidth-1:0]    clamped;
  logic [2*RawWidth-1:0]  product;
  logic [RawWidth-1:0]    level_full;

  assign cfg_i.ready = 1'b1;

  // handshake: a stage advances when the one after it is free or draining
  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_acc     = in_i.valid && s1_ready;

  always_comb begin
    // trigger: load on an idle start, then count down while nonzero
    trig_load = trig_rem_q;
    if (in_i.start_request && (trig_rem_q == '0) && !waiting_q) begin
      trig_load = trigger_ticks_q;
    end
    s1_d.trigger_out = (trig_load != '0);
    trig_rem_d       = s1_d.trigger_out ? (trig_load - 1'b1) : trig_load;

    // echo counter saturates while waiting for the falling edge
    cnt_inc = echo_cnt_q;
    if (waiting_q && (echo_cnt_q != CountMax)) begin
      cnt_inc = echo_cnt_q + 1'b1;
    end

    rise = in_i.echo_level && !prev_echo_q;
    fall = !in_i.echo_level && prev_echo_q && waiting_q;

    echo_cnt_d        = cnt_inc;
    waiting_d         = waiting_q;
    s1_d.result_valid = 1'b0;
    if (rise) begin
      echo_cnt_d = '0;
      waiting_d  = 1'b1;
    end else if (fall) begin
      waiting_d         = 1'b0;
      s1_d.result_valid = 1'b1;
    end
    prev_echo_d = in_i.echo_level;

    // clamp into [min, max]; when crossed, counts below min give min, others max
    if (cnt_inc < COUNT_WIDTH'(min_count_q)) begin
      clamped = min_count_q;
    end else if (cnt_inc > COUNT_WIDTH'(max_count_q)) begin
      clamped = max_count_q;
    end else begin
      clamped = cnt_inc[RawWidth-1:0];
    end

    s1_d.diff      = '0;
    s1_d.raw_count = '0;
    if (s1_d.result_valid) begin
      s1_d.diff      = (clamped >= min_count_q) ? (clamped - min_count_q) : '0;
      s1_d.raw_count = (cnt_inc > COUNT_WIDTH'(RawMax)) ? RawMax
                                                       : cnt_inc[RawWidth-1:0];
    end
  end

  // stage 2: scale to Q8 percent and limit
  always_comb begin
    product    = s1_q.diff * scale_factor_q;
    level_full = product[2*RawWidth-1:RawWidth];
    out_d.trigger_out  = s1_q.trigger_out;
    out_d.result_valid = s1_q.result_valid;
    out_d.raw_count    = s1_q.raw_count;
    out_d.level_q8     = (level_full > RawWidth'(LevelLimit)) ? LevelLimit
                                                              : level_full[LevelWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_ticks_q <= TriggerTicksReset;
      min_count_q     <= MinCountReset;
      max_count_q     <= MaxCountReset;
      scale_factor_q  <= ScaleFactorReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegTriggerTicks: trigger_ticks_q <= cfg_i.data;
        RegMinCount:     min_count_q     <= cfg_i.data;
        RegMaxCount:     max_count_q     <= cfg_i.data;
        RegScaleFactor:  scale_factor_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_echo_q <= 1'b0;
      trig_rem_q  <= '0;
      waiting_q   <= 1'b0;
      echo_cnt_q  <= '0;
    end else if (in_acc) begin
      prev_echo_q <= prev_echo_d;
      trig_rem_q  <= trig_rem_d;
      waiting_q   <= waiting_d;
      echo_cnt_q  <= echo_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.trigger_out  = out_q.trigger_out;
  assign out_o.result_valid = out_q.result_valid;
  assign out_o.level_q8     = out_q.level_q8;
  assign out_o.raw_count    = out_q.raw_count;

  // a rising echo edge always arms the fall detector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rise |=> waiting_q)
    else $error("rising echo did not set waiting");

  // a saturated counter stays put until the next rising edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && waiting_q && (echo_cnt_q == CountMax) && !rise |=> echo_cnt_q == CountMax)
    else $error("echo counter wrapped");

  // a held stage 1 item keeps its payload while stage 2 is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q))
    else $error("stage 1 item lost under stall");

  // the delivered level never passes full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.level_q8 <= LevelLimit)
    else $error("level above limit");

endmodule
